### src/sftp_pkg.sv
// ----------------------------------------------------------------------------
// sftp_pkg
// Shared types and defaults for the signed fraction text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sftp_pkg;

   localparam int MAG_BITS_DEF = 31;
   localparam int OUT_MAG_W    = 31;
   localparam int CHAR_W       = 8;
   localparam int RSP_DATA_W   = 72;

   typedef struct packed {
      logic                 overflow;
      logic                 denom_zero;
      logic [OUT_MAG_W-1:0] denominator;
      logic [OUT_MAG_W-1:0] numerator;
      logic                 negative;
      logic                 format_ok;
   } rsp_type;

endpackage

`default_nettype wire

### src/sftp_parse_core.sv
// ----------------------------------------------------------------------------
// sftp_parse_core
// Per-character line state: format check, sign parity and the two
// saturating decimal accumulators, plus the result formed from that state.
// ----------------------------------------------------------------------------
`default_nettype none

module sftp_parse_core
   import sftp_pkg::*;
#(
   parameter int MAG_BITS = MAG_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [CHAR_W-1:0] char_code,
   input  wire logic              is_end,
   output rsp_type                result
);

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_DIGIT = 2'd1,
      KIND_SLASH = 2'd2,
      KIND_MINUS = 2'd3
   } kind_type;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam int ACC_W = MAG_BITS + 4;
   localparam int EXT_W = (MAG_BITS > OUT_MAG_W) ? MAG_BITS : OUT_MAG_W;
   localparam logic [ACC_W-1:0] MAG_MAX = {4'b0, {MAG_BITS{1'b1}}};
   localparam logic [MAG_BITS-1:0] DEN_RESET = MAG_BITS'(1);

   logic                leading_done_ff, leading_done_in;
   logic                pending_space_ff, pending_space_in;
   kind_type            prev_kind_ff, prev_kind_in;
   logic                slash_seen_ff, slash_seen_in;
   logic                bad_format_ff, bad_format_in;
   logic                minus_parity_ff, minus_parity_in;
   logic [MAG_BITS-1:0] num_acc_ff, num_acc_in;
   logic [MAG_BITS-1:0] den_acc_ff, den_acc_in;
   logic                overflow_ff, overflow_in;

   logic [3:0]          digit;
   logic                is_digit;
   logic [ACC_W-1:0]    acc_ext;
   logic [ACC_W-1:0]    acc_sum;
   logic                acc_sat;
   logic [MAG_BITS-1:0] acc_next;
   logic [EXT_W-1:0]    num_ext;
   logic [EXT_W-1:0]    den_ext;

   // shared times-ten accumulate for whichever magnitude is active
   always_comb begin
      digit      = 4'(char_code - CHAR_ZERO);
      is_digit   = char_code inside {[CHAR_ZERO:CHAR_NINE]};
      acc_ext    = ACC_W'(slash_seen_ff ? den_acc_ff : num_acc_ff);
      acc_sum    = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(digit);
      acc_sat    = acc_sum > MAG_MAX;
      acc_next   = acc_sat ? {MAG_BITS{1'b1}} : acc_sum[MAG_BITS-1:0];
   end

   always_comb begin
      leading_done_in  = leading_done_ff;
      pending_space_in = pending_space_ff;
      prev_kind_in     = prev_kind_ff;
      slash_seen_in    = slash_seen_ff;
      bad_format_in    = bad_format_ff;
      minus_parity_in  = minus_parity_ff;
      num_acc_in       = num_acc_ff;
      den_acc_in       = den_acc_ff;
      overflow_in      = overflow_ff;
      if (take) begin
         if (is_end) begin
            leading_done_in  = 1'b0;
            pending_space_in = 1'b0;
            prev_kind_in     = KIND_START;
            slash_seen_in    = 1'b0;
            bad_format_in    = 1'b0;
            minus_parity_in  = 1'b0;
            num_acc_in       = '0;
            den_acc_in       = DEN_RESET;
            overflow_in      = 1'b0;
         end else if (!bad_format_ff) begin
            if (char_code == CHAR_SPACE) begin
               if (leading_done_ff && prev_kind_ff != KIND_SLASH) begin
                  pending_space_in = 1'b1;
               end
            end else begin
               leading_done_in = 1'b1;
               if (char_code == CHAR_SLASH) begin
                  if (slash_seen_ff) begin
                     bad_format_in = 1'b1;
                  end else begin
                     pending_space_in = 1'b0;
                     slash_seen_in    = 1'b1;
                     den_acc_in       = '0;
                     prev_kind_in     = KIND_SLASH;
                  end
               end else if (pending_space_ff) begin
                  bad_format_in = 1'b1;
               end else if (is_digit) begin
                  if (slash_seen_ff) begin
                     den_acc_in = acc_next;
                  end else begin
                     num_acc_in = acc_next;
                  end
                  if (acc_sat) begin
                     overflow_in = 1'b1;
                  end
                  prev_kind_in = KIND_DIGIT;
               end else if (char_code == CHAR_MINUS && prev_kind_ff != KIND_DIGIT) begin
                  minus_parity_in = !minus_parity_ff;
                  prev_kind_in    = KIND_MINUS;
               end else begin
                  bad_format_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leading_done_ff  <= 1'b0;
         pending_space_ff <= 1'b0;
         prev_kind_ff     <= KIND_START;
         slash_seen_ff    <= 1'b0;
         bad_format_ff    <= 1'b0;
         minus_parity_ff  <= 1'b0;
         num_acc_ff       <= '0;
         den_acc_ff       <= DEN_RESET;
         overflow_ff      <= 1'b0;
      end else begin
         leading_done_ff  <= leading_done_in;
         pending_space_ff <= pending_space_in;
         prev_kind_ff     <= prev_kind_in;
         slash_seen_ff    <= slash_seen_in;
         bad_format_ff    <= bad_format_in;
         minus_parity_ff  <= minus_parity_in;
         num_acc_ff       <= num_acc_in;
         den_acc_ff       <= den_acc_in;
         overflow_ff      <= overflow_in;
      end
   end

   always_comb begin
      num_ext = EXT_W'(num_acc_ff);
      den_ext = EXT_W'(den_acc_ff);
      result  = '0;
      if (!bad_format_ff) begin
         result.format_ok   = 1'b1;
         result.negative    = minus_parity_ff;
         result.numerator   = num_ext[OUT_MAG_W-1:0];
         result.denominator = den_ext[OUT_MAG_W-1:0];
         result.denom_zero  = (den_acc_ff == '0);
         result.overflow    = overflow_ff;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && is_end |=> !slash_seen_ff && !bad_format_ff && !overflow_ff
                         && num_acc_ff == '0 && den_acc_ff == DEN_RESET)
      else $error("line state not cleared after end beat");

   a_no_slash_den_one: assert property (@(posedge clock) disable iff (reset)
      !slash_seen_ff |-> den_acc_ff == DEN_RESET)
      else $error("denominator changed without a slash");

   a_slash_kind: assert property (@(posedge clock) disable iff (reset)
      prev_kind_ff == KIND_SLASH |-> slash_seen_ff)
      else $error("slash kind without slash seen");

   a_space_needs_lead: assert property (@(posedge clock) disable iff (reset)
      pending_space_ff |-> leading_done_ff)
      else $error("pending space before any text");

   a_bad_holds: assert property (@(posedge clock) disable iff (reset)
      bad_format_ff && !(take && is_end) |=> bad_format_ff && $stable(num_acc_ff))
      else $error("state moved after a format error");

endmodule

`default_nettype wire

### src/signed_fraction_text_parser_top.sv
// ----------------------------------------------------------------------------
// signed_fraction_text_parser_top
// Parses a text line, one character per beat, into a signed fraction.
//
//   channel | dir | handshake          | payload
//   req_    | in  | tvalid/tready      | tdata = char_code, tlast = is_end
//   rsp_    | out | tvalid/tready      | tdata = result fields, one per line
//
// One character per cycle unless a line end stalls; an accepted beat waits in the input register until applied.
// The result of a line is registered at the same edge its tlast beat applies.
// Characters keep flowing while a result waits; only a second line end stalls
// until the held result is taken. Reset is synchronous; it clears the valid flags and the core line state.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_fraction_text_parser_top
   import sftp_pkg::*;
#(
   parameter int MAG_BITS = MAG_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata    // [0] format_ok, [1] negative,
                                                   // [32:2] numerator,
                                                   // [63:33] denominator,
                                                   // [64] denom_zero, [65] overflow
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           core_result;
   logic              apply;
   logic              req_take;

   assign apply      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || apply;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (apply) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (apply && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (apply && in_last_ff) begin
         rsp_data_ff <= core_result;
      end
   end

   sftp_parse_core #(
      .MAG_BITS (MAG_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (apply),
      .char_code (in_char_ff),
      .is_end    (in_last_ff),
      .result    (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_data_ff.overflow,
                        rsp_data_ff.denom_zero,
                        rsp_data_ff.denominator,
                        rsp_data_ff.numerator,
                        rsp_data_ff.negative,
                        rsp_data_ff.format_ok};

endmodule

`default_nettype wire
